>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddf assertion failed");

// Next-cycle implication.
`define DDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddf assertion failed");

`endif

>>> hw/rtl/ddf_pkg.sv
// ----------------------------------------------------------------------------
// ddf_pkg
// Widths, codes and pipeline word types of the digit display formatter.
// ----------------------------------------------------------------------------
package ddf_pkg;

    localparam int DIGIT_COUNT   = 4;
    localparam int VALUE_W       = 15;
    localparam int MAG_W         = 14;
    localparam int DIG_W         = 4;
    localparam int ADDR_W        = 3;
    localparam int EXTRACT_COUNT = 4;
    localparam int DIV_STAGES    = EXTRACT_COUNT - 1;
    localparam int POS_W         = $clog2(DIGIT_COUNT + 1);
    localparam int IDX_W         = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int SIG_W         = $clog2(EXTRACT_COUNT + 1);

    localparam int RECIP_W       = 16;
    localparam int RECIP_SHIFT   = 19;
    localparam int QUOT_W        = MAG_W - 3;
    localparam int PROD_W        = MAG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 16'd52429;

    localparam logic signed [VALUE_W-1:0] UNSIGNED_MAX = 15'sd9999;
    localparam logic signed [VALUE_W-1:0] SIGNED_LIMIT = 15'sd999;

    localparam logic [DIG_W-1:0] CODE_MINUS = 4'd10;
    localparam logic [DIG_W-1:0] CODE_BLANK = 4'd15;

    typedef struct packed {
        logic                                neg;
        logic [MAG_W-1:0]                    rest;
        logic [EXTRACT_COUNT-1:0][DIG_W-1:0] digits;
    } t_work;

    typedef logic [DIGIT_COUNT-1:0][DIG_W-1:0] t_codes;

endpackage

>>> hw/rtl/ddf_range.sv
// ----------------------------------------------------------------------------
// ddf_range
// Range check against the mode, sign split and magnitude register.
// ----------------------------------------------------------------------------
module ddf_range (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [ddf_pkg::VALUE_W-1:0]    i_value,
    input  logic                                  i_mode,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output ddf_pkg::t_work                        o_work
);

    logic           r_valid;
    ddf_pkg::t_work r_work;
    logic           n_valid;
    ddf_pkg::t_work n_work;
    logic           in_range;
    logic           neg;
    logic [ddf_pkg::VALUE_W-1:0] abs_val;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        if (i_mode) begin
            in_range = (i_value >= -ddf_pkg::SIGNED_LIMIT) && (i_value <= ddf_pkg::SIGNED_LIMIT);
        end else begin
            in_range = !i_value[ddf_pkg::VALUE_W-1] && (i_value <= ddf_pkg::UNSIGNED_MAX);
        end
        neg     = i_value[ddf_pkg::VALUE_W-1];
        abs_val = neg ? (~i_value + 1'b1) : i_value;
        n_work        = '0;
        n_work.neg    = i_mode && neg;
        n_work.rest   = abs_val[ddf_pkg::MAG_W-1:0];
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid && in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

>>> hw/rtl/ddf_digit_stage.sv
// ----------------------------------------------------------------------------
// ddf_digit_stage
// One divide-by-ten step: reciprocal multiply, remainder, digit shift-in.
// ----------------------------------------------------------------------------
module ddf_digit_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ddf_pkg::t_work i_work,
    output logic           o_valid,
    input  logic           i_ready,
    output ddf_pkg::t_work o_work
);

    logic                         r_valid;
    ddf_pkg::t_work               r_work;
    logic                         n_valid;
    ddf_pkg::t_work               n_work;
    logic [ddf_pkg::PROD_W-1:0]   prod;
    logic [ddf_pkg::MAG_W-1:0]    quot;
    logic [ddf_pkg::MAG_W-1:0]    rem;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        prod = ddf_pkg::PROD_W'(i_work.rest) * ddf_pkg::PROD_W'(ddf_pkg::RECIP_TEN);
        quot = ddf_pkg::MAG_W'(prod[ddf_pkg::RECIP_SHIFT +: ddf_pkg::QUOT_W]);
        rem  = i_work.rest - (quot << 3) - (quot << 1);
        n_work      = i_work;
        n_work.rest = quot;
        for (int i = 0; i < ddf_pkg::EXTRACT_COUNT - 1; i++) begin
            n_work.digits[i] = i_work.digits[i+1];
        end
        n_work.digits[ddf_pkg::EXTRACT_COUNT-1] = rem[ddf_pkg::DIG_W-1:0];
        n_valid = o_ready ? i_valid : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

>>> hw/rtl/ddf_blank.sv
// ----------------------------------------------------------------------------
// ddf_blank
// Leading blanking and minus placement over the extracted digits.
// ----------------------------------------------------------------------------
module ddf_blank (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ddf_pkg::t_work  i_work,
    output logic            o_valid,
    input  logic            i_ready,
    output ddf_pkg::t_codes o_codes
);

    logic                                         r_valid;
    ddf_pkg::t_codes                              r_codes;
    logic                                         n_valid;
    ddf_pkg::t_codes                              n_codes;
    logic [ddf_pkg::EXTRACT_COUNT-1:0][ddf_pkg::DIG_W-1:0] dig;
    logic [ddf_pkg::SIG_W-1:0]                    sig;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        for (int p = 0; p < ddf_pkg::EXTRACT_COUNT - 1; p++) begin
            dig[p] = i_work.digits[p+1];
        end
        dig[ddf_pkg::EXTRACT_COUNT-1] = i_work.rest[ddf_pkg::DIG_W-1:0];
        sig = ddf_pkg::SIG_W'(1);
        for (int p = 1; p < ddf_pkg::EXTRACT_COUNT; p++) begin
            if (dig[p] != '0) begin
                sig = ddf_pkg::SIG_W'(p + 1);
            end
        end
        for (int p = 0; p < ddf_pkg::DIGIT_COUNT; p++) begin
            n_codes[p] = ddf_pkg::CODE_BLANK;
            if (p < ddf_pkg::EXTRACT_COUNT && p < int'(sig)) begin
                n_codes[p] = dig[p % ddf_pkg::EXTRACT_COUNT];
            end else if (i_work.neg && p == int'(sig)) begin
                n_codes[p] = ddf_pkg::CODE_MINUS;
            end
        end
        n_valid = o_ready ? i_valid : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (o_ready && i_valid) begin
            r_codes <= n_codes;
        end
    end

    assign o_valid = r_valid;
    assign o_codes = r_codes;

endmodule

>>> hw/rtl/ddf_serializer.sv
// ----------------------------------------------------------------------------
// ddf_serializer
// Issue DIGIT_COUNT digit writes per word, highest address first.
// ----------------------------------------------------------------------------
module ddf_serializer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  ddf_pkg::t_codes              i_codes,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ddf_pkg::ADDR_W-1:0]   o_digit_address,
    output logic [ddf_pkg::DIG_W-1:0]    o_digit_code,
    output logic                         o_last
);

    logic                        r_valid;
    logic [ddf_pkg::POS_W-1:0]   r_pos;
    ddf_pkg::t_codes             r_codes;
    logic [ddf_pkg::POS_W-1:0]   idx;
    logic                        at_last;

    assign at_last = (r_pos == ddf_pkg::POS_W'(1));
    assign o_ready = !r_valid || (i_ready && at_last);
    assign idx     = r_pos - ddf_pkg::POS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= ddf_pkg::POS_W'(ddf_pkg::DIGIT_COUNT);
        end else if (o_ready) begin
            r_valid <= i_valid;
            r_pos   <= ddf_pkg::POS_W'(ddf_pkg::DIGIT_COUNT);
        end else if (i_ready) begin
            r_pos   <= r_pos - ddf_pkg::POS_W'(1);
        end
        if (o_ready && i_valid) begin
            r_codes <= i_codes;
        end
    end

    assign o_valid         = r_valid;
    assign o_digit_address = ddf_pkg::ADDR_W'(r_pos);
    assign o_digit_code    = r_codes[idx[ddf_pkg::IDX_W-1:0]];
    assign o_last          = at_last;

endmodule

>>> hw/rtl/decimal_digit_display_formatter_core.sv
// ----------------------------------------------------------------------------
// decimal_digit_display_formatter_core
// Signed or unsigned number to blanked digit-register writes.
// ----------------------------------------------------------------------------
// Pipeline: the input word passes the range register, three divide-by-ten
// stages, the blanking register and the output register, in that order.
// Flow: the single output channel takes a new word only once the last digit
// write of the current word is taken; out-of-range words are accepted and give no output.
// Reset: synchronous, clears all valid flags and the write position;
// payload registers keep data.
// ----------------------------------------------------------------------------
module decimal_digit_display_formatter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ddf_pkg::VALUE_W-1:0]  i_value,
    input  logic                                i_mode,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ddf_pkg::ADDR_W-1:0]          o_digit_address,
    output logic [ddf_pkg::DIG_W-1:0]           o_digit_code,
    output logic                                o_last
);

    logic           stg_valid [ddf_pkg::DIV_STAGES+1];
    logic           stg_ready [ddf_pkg::DIV_STAGES+1];
    ddf_pkg::t_work stg_work  [ddf_pkg::DIV_STAGES+1];
    logic            blk_valid;
    logic            blk_ready;
    ddf_pkg::t_codes blk_codes;

    ddf_range u_range (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .i_mode  (i_mode),
        .o_valid (stg_valid[0]),
        .i_ready (stg_ready[0]),
        .o_work  (stg_work[0])
    );

    for (genvar g = 0; g < ddf_pkg::DIV_STAGES; g++) begin : g_div
        ddf_digit_stage u_digit (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g]),
            .i_work  (stg_work[g]),
            .o_valid (stg_valid[g+1]),
            .i_ready (stg_ready[g+1]),
            .o_work  (stg_work[g+1])
        );
    end

    ddf_blank u_blank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid[ddf_pkg::DIV_STAGES]),
        .o_ready (stg_ready[ddf_pkg::DIV_STAGES]),
        .i_work  (stg_work[ddf_pkg::DIV_STAGES]),
        .o_valid (blk_valid),
        .i_ready (blk_ready),
        .o_codes (blk_codes)
    );

    ddf_serializer u_ser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (blk_valid),
        .o_ready         (blk_ready),
        .i_codes         (blk_codes),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_digit_address (o_digit_address),
        .o_digit_code    (o_digit_code),
        .o_last          (o_last)
    );

endmodule

>>> hw/rtl/ddf_checker.sv
// ----------------------------------------------------------------------------
// ddf_checker
// Port-level checks on the digit write sequence, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ddf_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [ddf_pkg::ADDR_W-1:0]  i_addr,
    input  logic [ddf_pkg::DIG_W-1:0]   i_code,
    input  logic                        i_last
);

    logic out_take;
    logic take_mid;
    logic take_end;
    logic last_shown;
    logic code_digit;
    logic addr_one;
    logic [ddf_pkg::ADDR_W-1:0] first_addr;
    logic [ddf_pkg::ADDR_W-1:0] next_addr;

    assign out_take   = i_out_valid && i_out_ready;
    assign take_mid   = out_take && !i_last;
    assign take_end   = out_take && i_last;
    assign last_shown = i_out_valid && i_last;
    assign code_digit = (i_code != ddf_pkg::CODE_BLANK) && (i_code != ddf_pkg::CODE_MINUS);
    assign addr_one   = (i_addr == ddf_pkg::ADDR_W'(1));
    assign first_addr = ddf_pkg::ADDR_W'(ddf_pkg::DIGIT_COUNT);
    assign next_addr  = i_addr - ddf_pkg::ADDR_W'(1);

    `DDF_ASSERT_IMP(a_last_at_one, i_clk, i_rst_n, last_shown, addr_one)
    `DDF_ASSERT_NXT(a_addr_steps, i_clk, i_rst_n, take_mid, i_out_valid && i_addr == $past(next_addr))
    `DDF_ASSERT_NXT(a_run_restarts, i_clk, i_rst_n, take_end, !i_out_valid || i_addr == first_addr)
    `DDF_ASSERT_IMP(a_units_digit, i_clk, i_rst_n, last_shown, code_digit)

endmodule

bind decimal_digit_display_formatter_core ddf_checker u_ddf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_addr      (o_digit_address),
    .i_code      (o_digit_code),
    .i_last      (o_last)
);
